[sv/srsgd_pkg.sv]
package srsgd_pkg;

    // Shard geometry.
    localparam int MAX_ROWS    = 256;
    localparam int ROW_WIDTH   = 16;
    localparam int STORE_DEPTH = MAX_ROWS * ROW_WIDTH;
    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Field widths.
    localparam int DATA_W  = 32;
    localparam int RATE_W  = 24;
    localparam int OFFS_W  = 31;
    localparam int ROWS_W  = 9;
    localparam int PROD_W  = DATA_W + RATE_W;
    localparam int FRAC_W  = 16;

    // Request types.
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_APPLIED = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_NEG_ID  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RATE   = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_ROWS   = 2'd2;

    // Configuration reset values.
    localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;
    localparam logic [OFFS_W-1:0] OFFS_RESET = 31'd0;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd256;

    // Outcome of decoding one request.
    typedef struct packed {
        logic              hit;
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } t_req_ctl;

endpackage

[sv/srsgd_ram.sv]
module srsgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/srsgd_decode.sv]
module srsgd_decode (
    input  logic [1:0]                    i_req_type,
    input  logic [31:0]                   i_key_id,
    input  logic [3:0]                    i_col,
    input  logic [srsgd_pkg::OFFS_W-1:0]  i_id_offset,
    input  logic [srsgd_pkg::ROWS_W-1:0]  i_rows_in_use,
    output srsgd_pkg::t_req_ctl           o_ctl
);
    import srsgd_pkg::*;

    logic [32:0] row_full;
    logic [31:0] rows_lim;
    logic        row_ok;
    logic        col_ok;
    logic        type_ok;

    // Updates address by global id; reads and writes by local row.
    always_comb begin
        if (i_req_type == REQ_UPDATE) begin
            row_full = {1'b0, i_key_id} - {2'b00, i_id_offset};
        end else begin
            row_full = {1'b0, i_key_id};
        end
    end

    assign rows_lim = (32'(i_rows_in_use) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                          : 32'(i_rows_in_use);
    assign row_ok   = !row_full[32] && (row_full[31:0] < rows_lim);
    assign col_ok   = {28'd0, i_col} < 32'(ROW_WIDTH);

    always_comb begin
        case (i_req_type)
            REQ_UPDATE, REQ_WRITE, REQ_READ: type_ok = 1'b1;
            default:                         type_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_ctl.hit    = 1'b0;
        o_ctl.status = ST_SKIPPED;
        if (type_ok) begin
            if (i_key_id[31]) begin
                o_ctl.status = ST_NEG_ID;
            end else if (row_ok && col_ok) begin
                o_ctl.hit    = 1'b1;
                o_ctl.status = ST_APPLIED;
            end
        end
        o_ctl.addr = ADDR_W'(ADDR_W'(row_full[ROW_W-1:0]) * ADDR_W'(ROW_WIDTH)
                             + ADDR_W'(i_col));
    end

endmodule

[sv/srsgd_alu.sv]
module srsgd_alu (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [srsgd_pkg::DATA_W-1:0]  i_value,
    input  logic [srsgd_pkg::RATE_W-1:0]  i_rate,
    input  logic [srsgd_pkg::DATA_W-1:0]  i_weight,
    output logic [srsgd_pkg::DATA_W-1:0]  o_weight
);
    import srsgd_pkg::*;

    localparam int STEP_W = PROD_W - FRAC_W;
    localparam int DIFF_W = STEP_W + 1;

    logic signed [PROD_W:0]   prod_full;
    logic        [PROD_W-1:0] r_prod;
    logic        [STEP_W-1:0] step;
    logic        [DIFF_W-1:0] diff;
    logic                     ovf;

    assign prod_full = $signed(i_value) * $signed({1'b0, i_rate});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= prod_full[PROD_W-1:0];
        end
    end

    // Dropping the low bits of a two's complement product rounds toward minus infinity.
    assign step = r_prod[PROD_W-1:FRAC_W];
    assign diff = {{(DIFF_W-DATA_W){i_weight[DATA_W-1]}}, i_weight}
                - {step[STEP_W-1], step};

    // Overflow when the bits above the result's sign disagree with it.
    assign ovf = (diff[DIFF_W-1:DATA_W-1] != {(DIFF_W-DATA_W+1){1'b0}})
              && (diff[DIFF_W-1:DATA_W-1] != {(DIFF_W-DATA_W+1){1'b1}});

    always_comb begin
        if (!ovf) begin
            o_weight = diff[DATA_W-1:0];
        end else if (diff[DIFF_W-1]) begin
            o_weight = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_weight = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

[sv/sparse_row_sgd_update.sv]
// Sparse-row SGD weight store for one shard of an embedding table.
// Input channel: i_in_valid / o_in_stall with the request fields. Each beat
// is a gradient update (global feature id), a weight write or a weight read
// (local row). Output channel: o_out_valid / i_out_stall with read_data,
// status and last_out; every input beat gives exactly one output beat.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// the port is always ready and should only be written while the block is idle.
// After an input beat is accepted, the weight RAM read is issued at the accepting
// edge, the gradient-times-rate product is registered in the multiply state
// (S_MUL), and the saturated write-back (S_WB) loads the output register. One
// item is in flight at a time, so the block takes a new item only once the last
// has left write-back. The output register lets the next item be accepted while
// a result waits; if it is still held by a stall at write-back, the sequencer
// waits.
// Synchronous reset restores the configuration defaults and clears control
// state. The weight RAM is not cleared: entries are undefined until written.
module sparse_row_sgd_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_key_id,
    input  logic [3:0]  i_col,
    input  logic [31:0] i_value,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status,
    output logic        o_last_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import srsgd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [RATE_W-1:0] r_rate;
    logic [OFFS_W-1:0] r_offset;
    logic [ROWS_W-1:0] r_rows;

    logic [1:0]        r_type;
    logic              r_hit;
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_value;
    logic              r_last;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic [1:0]        r_status_out;
    logic              r_last_out;

    t_req_ctl          dec_ctl;
    logic              in_accept;
    logic              cfg_write;
    logic              out_free;
    logic              wb_fire;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] alu_weight;
    logic [DATA_W-1:0] wb_wdata;
    logic [DATA_W-1:0] wb_result;

    srsgd_decode u_decode (
        .i_req_type    (i_req_type),
        .i_key_id      (i_key_id),
        .i_col         (i_col),
        .i_id_offset   (r_offset),
        .i_rows_in_use (r_rows),
        .o_ctl         (dec_ctl)
    );

    srsgd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wb_wdata),
        .i_re    (in_accept),
        .i_raddr (dec_ctl.addr),
        .o_rdata (ram_rdata)
    );

    srsgd_alu u_alu (
        .i_clk    (i_clk),
        .i_load   (r_state == S_MUL),
        .i_value  (r_value),
        .i_rate   (r_rate),
        .i_weight (ram_rdata),
        .o_weight (alu_weight)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign wb_fire     = (r_state == S_WB) && out_free;
    assign ram_we      = wb_fire && r_hit && ((r_type == REQ_UPDATE) || (r_type == REQ_WRITE));
    assign wb_wdata    = (r_type == REQ_WRITE) ? r_value : alu_weight;

    // The RAM read data holds from the read until the next accepted beat.
    always_comb begin
        if (!r_hit) begin
            wb_result = '0;
        end else if (r_type == REQ_READ) begin
            wb_result = ram_rdata;
        end else begin
            wb_result = wb_wdata;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_accept) n_state = S_MUL;
            S_MUL:   n_state = S_WB;
            S_WB:    if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rate      <= RATE_RESET;
            r_offset    <= OFFS_RESET;
            r_rows      <= ROWS_RESET;
        end else begin
            r_state <= n_state;
            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                case (i_cfg_index)
                    CFG_RATE:   r_rate   <= i_cfg_data[RATE_W-1:0];
                    CFG_OFFSET: r_offset <= i_cfg_data[OFFS_W-1:0];
                    CFG_ROWS:   r_rows   <= i_cfg_data[ROWS_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_type   <= i_req_type;
            r_hit    <= dec_ctl.hit;
            r_status <= dec_ctl.status;
            r_addr   <= dec_ctl.addr;
            r_value  <= i_value;
            r_last   <= i_last;
        end
        if (wb_fire) begin
            r_read_data  <= wb_result;
            r_status_out <= r_status;
            r_last_out   <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status_out;
    assign o_last_out  = r_last_out;

    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_MUL)
        else $error("accepted beat did not move to the multiply step");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_WB)
        else $error("result loaded outside write-back");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status_out != ST_APPLIED)) |-> r_read_data == '0)
        else $error("skipped or failed result carries non-zero data");

    a_write_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_status == ST_APPLIED) && (r_state == S_WB))
        else $error("weight RAM written for a request that was not applied");

endmodule

[verif/tb_sparse_row_sgd_update.sv]
`timescale 1ns / 100ps

import srsgd_pkg::*;

// Request code that the block decodes as unused.
localparam logic [1:0] REQ_UNUSED = 2'd3;

localparam longint WEIGHT_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
localparam longint WEIGHT_MIN = -WEIGHT_MAX - 1;

typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] key_id;
    logic [3:0]               col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
} t_request;

typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic [1:0]               status;
    logic                     last;
} t_result;

// Mirror of the shard's weights and registers, plus the queue of results owed.
class weight_scoreboard;
    logic signed [DATA_W-1:0] weights [STORE_DEPTH];
    logic [RATE_W-1:0]        rate;
    logic [OFFS_W-1:0]        offset;
    logic [ROWS_W-1:0]        rows_owned;
    t_result                  expected [$];
    int errors, noted, checked, applied, skipped, neg_ids, saturated;

    function new();
        rate       = RATE_RESET;
        offset     = OFFS_RESET;
        rows_owned = ROWS_RESET;
    endfunction

    function void set_register(input logic [1:0] index, input logic [31:0] data);
        case (index)
            CFG_RATE:   rate = data[RATE_W-1:0];
            CFG_OFFSET: offset = data[OFFS_W-1:0];
            CFG_ROWS:   rows_owned = data[ROWS_W-1:0];
            default:    ;
        endcase
    endfunction

    // True when the request lands on a weight inside the shard.
    function bit locate(input t_request req, output int unsigned addr);
        longint row;
        longint limit;
        addr = 0;
        if (req.kind != REQ_UPDATE && req.kind != REQ_WRITE && req.kind != REQ_READ)
            return 1'b0;
        if (req.key_id < 0)
            return 1'b0;
        row = longint'($signed(req.key_id));
        if (req.kind == REQ_UPDATE)
            row = row - longint'(offset);
        limit = longint'((rows_owned > MAX_ROWS) ? MAX_ROWS : rows_owned);
        if (row < 0 || row >= limit || req.col >= ROW_WIDTH)
            return 1'b0;
        addr = 32'(row * ROW_WIDTH + longint'(req.col));
        return addr < STORE_DEPTH;
    endfunction

    function void note_request(input t_request req);
        t_result     want;
        int unsigned addr;
        longint      prod;
        longint      diff;
        want.weight = '0;
        want.last   = req.last;
        noted++;
        if (locate(req, addr)) begin
            case (req.kind)
                REQ_UPDATE: begin
                    // Arithmetic shift of the signed product rounds toward minus infinity.
                    prod = longint'($signed(req.value)) * longint'(rate);
                    diff = longint'($signed(weights[addr])) - (prod >>> FRAC_W);
                    if (diff > WEIGHT_MAX) begin
                        diff = WEIGHT_MAX;
                        saturated++;
                    end else if (diff < WEIGHT_MIN) begin
                        diff = WEIGHT_MIN;
                        saturated++;
                    end
                    weights[addr] = diff[DATA_W-1:0];
                end
                REQ_WRITE: weights[addr] = req.value;
                default:   ;
            endcase
            want.weight = weights[addr];
            want.status = ST_APPLIED;
            applied++;
        end else if (req.kind != REQ_UNUSED && req.key_id < 0) begin
            want.status = ST_NEG_ID;
            neg_ids++;
        end else begin
            want.status = ST_SKIPPED;
            skipped++;
        end
        expected.push_back(want);
    endfunction

    task report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        errors++;
    endtask

    task check_result(input t_result got);
        t_result want;
        if (expected.size() == 0) begin
            report_mismatch($sformatf("result with nothing owed: weight %0d status %0d",
                                      got.weight, got.status));
            return;
        end
        want = expected.pop_front();
        checked++;
        if (got.weight !== want.weight)
            report_mismatch($sformatf("result %0d read_data %0d, want %0d",
                                      checked, got.weight, want.weight));
        if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      checked, got.status, want.status));
        if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last_out %0b, want %0b",
                                      checked, got.last, want.last));
    endtask
endclass

module tb_sparse_row_sgd_update;

    localparam int STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [31:0] i_key_id;
    logic [3:0]  i_col;
    logic [31:0] i_value;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_read_data;
    logic [1:0]  o_status;
    logic        o_last_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    weight_scoreboard sb;
    bit               loaded [STORE_DEPTH];
    bit               calm;
    int               settings = 1;
    int               quiet_cycles = 0;

    sparse_row_sgd_update dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.weight = o_read_data;
            got.status = o_status;
            got.last   = o_last_out;
            sb.check_result(got);
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == STALL_LIMIT) begin
                $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver back-pressure in bursts, switched off for the closing stretch.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input t_request req, input bit gaps);
        int unsigned addr;
        if (sb.locate(req, addr)) begin
            // Never update or read a weight that has not been loaded; load it instead.
            if (req.kind != REQ_WRITE && !loaded[addr]) begin
                req.kind   = REQ_WRITE;
                req.key_id = addr / ROW_WIDTH;
            end
            loaded[addr] = 1'b1;
        end
        if (gaps && !calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req.kind;
        i_key_id     <= req.key_id;
        i_col        <= req.col;
        i_value      <= req.value;
        i_last       <= req.last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
    endtask

    task automatic directed_request(input logic [1:0] kind, input logic [31:0] id,
                                    input logic [3:0] col, input logic [31:0] value,
                                    input logic last);
        t_request req;
        req.kind   = kind;
        req.key_id = id;
        req.col    = col;
        req.value  = value;
        req.last   = last;
        send_request(req, 1'b0);
    endtask

    // Mostly well-formed traffic on a handful of hot rows, with some noise.
    function automatic t_request random_request();
        t_request                 req;
        int unsigned              roll;
        int unsigned              limit;
        longint                   row;
        logic signed [DATA_W-1:0] grad;
        limit = (sb.rows_owned > MAX_ROWS) ? MAX_ROWS : sb.rows_owned;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            req.kind = REQ_UPDATE;
        else if (roll < 65)
            req.kind = REQ_WRITE;
        else if (roll < 85)
            req.kind = REQ_READ;
        else if (roll < 90)
            req.kind = REQ_UNUSED;
        else
            req.kind = 2'($urandom_range(0, 3));

        roll = $urandom_range(0, 99);
        if (roll < 30)
            row = longint'($urandom_range(0, 1));
        else if (roll < 55)
            row = longint'((limit > 0) ? limit - 1 : 0);
        else if (roll < 70)
            row = longint'(limit / 2);
        else if (roll < 85)
            row = longint'($urandom_range(0, MAX_ROWS - 1));
        else
            row = longint'(limit + $urandom_range(0, 2));
        if (req.kind == REQ_UPDATE)
            req.key_id = 32'(longint'(sb.offset) + row);
        else
            req.key_id = 32'(row);

        roll = $urandom_range(0, 99);
        if (roll < 6)
            req.key_id = $urandom();
        else if (roll < 9)
            req.key_id = 32'(longint'(sb.offset) - $urandom_range(1, 4));

        req.col = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, ROW_WIDTH - 1))
                                              : 4'($urandom_range(0, 3));

        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            grad = $urandom_range(0, 32'h3FFFF);
            if ($urandom_range(0, 1) == 1)
                grad = -grad;
        end else if (roll < 80) begin
            grad = $urandom();
        end else if (roll < 90) begin
            grad = 32'h7FFF_FFFF;
        end else begin
            grad = 32'h8000_0000;
        end
        req.value = grad;
        req.last  = ($urandom_range(0, 7) == 0);
        return req;
    endfunction

    task automatic random_requests(input int count);
        for (int n = 0; n < count; n++)
            send_request(random_request(), 1'b1);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(index, data);
    endtask

    // Registers change only once the block has handed back every result.
    task automatic configure(input logic [RATE_W-1:0] rate, input logic [OFFS_W-1:0] offset,
                             input logic [ROWS_W-1:0] rows);
        i_in_valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        write_register(CFG_RATE, 32'(rate));
        write_register(CFG_OFFSET, 32'(offset));
        write_register(CFG_ROWS, 32'(rows));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_UPDATE;
        i_key_id     = '0;
        i_col        = '0;
        i_value      = '0;
        i_last       = 1'b0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_RATE;
        i_cfg_data   = '0;
        calm         = 1'b0;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: unit rate, no offset, every row owned.
        directed_request(REQ_WRITE,  32'd0,   4'd0,  32'h0001_0000, 1'b0);
        directed_request(REQ_READ,   32'd0,   4'd0,  32'h0,         1'b0);
        directed_request(REQ_UPDATE, 32'd0,   4'd0,  32'h0000_8000, 1'b0);
        directed_request(REQ_WRITE,  32'd255, 4'd15, 32'h7FFF_FFFF, 1'b0);
        directed_request(REQ_UPDATE, 32'd255, 4'd15, 32'h8000_0000, 1'b0);
        directed_request(REQ_WRITE,  32'd1,   4'd3,  32'h8000_0000, 1'b0);
        directed_request(REQ_UPDATE, 32'd1,   4'd3,  32'h7FFF_FFFF, 1'b1);
        directed_request(REQ_UPDATE, 32'd0,   4'd0,  32'hFFFF_FFFF, 1'b0);
        directed_request(REQ_READ,   32'd255, 4'd15, 32'h0,         1'b0);
        // Negative ids on every request type.
        directed_request(REQ_UPDATE, 32'h8000_0000, 4'd0, 32'h0001_0000, 1'b0);
        directed_request(REQ_WRITE,  32'hFFFF_FFFF, 4'd5, 32'h1234_5678, 1'b0);
        directed_request(REQ_READ,   32'hFFFF_FFFB, 4'd9, 32'h0,         1'b1);
        // Rows beyond the shard.
        directed_request(REQ_READ,   32'd256,       4'd0,  32'h0,         1'b0);
        directed_request(REQ_WRITE,  32'h7FFF_FFFF, 4'd15, 32'h5555_5555, 1'b0);
        directed_request(REQ_UPDATE, 32'd256,       4'd2,  32'h0001_0000, 1'b0);
        // The unused request code, with an ordinary and a negative id.
        directed_request(REQ_UNUSED, 32'd0,         4'd0,  32'hFFFF_FFFF, 1'b1);
        directed_request(REQ_UNUSED, 32'h8000_0001, 4'd1,  32'h0,         1'b0);
        directed_request(REQ_WRITE,  32'd128, 4'd7,  32'h0,         1'b0);
        directed_request(REQ_READ,   32'd128, 4'd7,  32'h0,         1'b0);
        directed_request(REQ_WRITE,  32'd255, 4'd0,  32'hFFFF_FFFF, 1'b0);
        directed_request(REQ_UPDATE, 32'd255, 4'd0,  32'h0,         1'b0);
        directed_request(REQ_READ,   32'd1,   4'd3,  32'h0,         1'b1);
        random_requests(100);

        configure(24'hFF_FFFF, 31'h7FFF_FFFF, 9'd256);
        random_requests(60);
        configure(24'd1, 31'd1000, 9'd1);
        random_requests(80);
        configure(24'd0, 31'd0, 9'd0);
        random_requests(40);
        configure(24'h01_8000, 31'd5, 9'd511);
        random_requests(120);
        configure(24'($urandom_range(1, 24'h03_FFFF)), 31'($urandom_range(0, 1 << 20)),
                  9'($urandom_range(1, MAX_ROWS)));
        random_requests(120);
        configure(24'($urandom()), 31'($urandom_range(0, 32'h7FFF_FFFF)),
                  9'($urandom_range(0, 511)));
        // The closing stretch runs with neither side holding back.
        calm = 1'b1;
        random_requests(150);

        i_in_valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Drove %0d requests under %0d register settings: %0d applied, %0d skipped,",
                 sb.noted, settings, sb.applied, sb.skipped);
        $display("%0d negative ids, %0d saturated updates; %0d results checked.",
                 sb.neg_ids, sb.saturated, sb.checked);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
sv/srsgd_pkg.sv
sv/srsgd_ram.sv
sv/srsgd_decode.sv
sv/srsgd_alu.sv
sv/sparse_row_sgd_update.sv
verif/tb_sparse_row_sgd_update.sv
